// ===== rtl/bit_field_stream_buffer_macros.svh =====
// Assertion helpers for the bit field stream buffer
`ifndef BIT_FIELD_STREAM_BUFFER_MACROS_SVH
`define BIT_FIELD_STREAM_BUFFER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BFSB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define BFSB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bfsb_pkg.sv =====
`default_nettype none

package bfsb_pkg;

    localparam int BUFFER_WORDS   = 512;
    localparam int MAX_FIELD_BITS = 32;
    localparam int DATA_W         = 32;
    localparam int CUR_W          = 15;
    localparam int CNT_W          = 6;
    localparam int ACT_W          = 3;
    localparam int SH_W           = $clog2(MAX_FIELD_BITS);
    localparam int WORD_AW        = $clog2(BUFFER_WORDS);
    localparam int BANK_AW        = WORD_AW - 1;
    localparam int BANK_DEPTH     = BUFFER_WORDS / 2;

    localparam logic [CUR_W-1:0] LIMIT_CAP   = CUR_W'(BUFFER_WORDS * MAX_FIELD_BITS);
    localparam logic [CUR_W-1:0] LIMIT_RESET = CUR_W'(16384);

    localparam logic [ACT_W-1:0] ACT_WR_U  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_WR_S  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_RD_U  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RD_S  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_SEEK  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd5;

    typedef struct packed {
        logic               is_read;
        logic               is_signed;
        logic               is_write;
        logic               sgn_present;
        logic [CNT_W-1:0]   width;
        logic [CNT_W-1:0]   part;
        logic [CNT_W-1:0]   ext;
        logic [SH_W-1:0]    sh;
        logic               lo_odd;
        logic [BANK_AW-1:0] even_addr;
        logic [BANK_AW-1:0] odd_addr;
        logic [DATA_W-1:0]  field;
        logic               ovf;
        logic [CUR_W-1:0]   cursor;
    } bfsb_op_t;

    typedef struct packed {
        logic               even_we;
        logic               odd_we;
        logic [BANK_AW-1:0] even_addr;
        logic [BANK_AW-1:0] odd_addr;
        logic [DATA_W-1:0]  even_data;
        logic [DATA_W-1:0]  odd_data;
    } bfsb_wr_t;

    function automatic logic [DATA_W-1:0] field_mask(input logic [CNT_W-1:0] w);
        logic [DATA_W-1:0] m;
        if (w >= CNT_W'(MAX_FIELD_BITS))
        begin
            m = '1;
        end
        else
        begin
            m = (DATA_W'(1) << w) - DATA_W'(1);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bfsb_bank.sv =====
`default_nettype none

module bfsb_bank import bfsb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rd_en,
    input  wire logic [BANK_AW-1:0] rd_addr,
    input  wire logic               wr_en,
    input  wire logic [BANK_AW-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]  wr_data,
    output logic      [DATA_W-1:0]  rd_data
);

    logic [DATA_W-1:0] mem [BANK_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // forward a write landing on the same edge
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= (wr_en && (wr_addr == rd_addr)) ? wr_data : mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/bfsb_ctrl.sv =====
`default_nettype none

module bfsb_ctrl import bfsb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [ACT_W-1:0] action,
    input  wire logic [DATA_W-1:0] value,
    input  wire logic [CNT_W-1:0] bit_count,
    input  wire logic [CUR_W-1:0] position,
    input  wire logic             bit_limit_we,
    input  wire logic [CUR_W-1:0] bit_limit,
    output bfsb_op_t              op
);

    logic [CUR_W-1:0]   cursor_reg;
    logic [CUR_W-1:0]   cursor_next;
    logic               overflow_reg;
    logic               overflow_next;
    logic [CUR_W-1:0]   bit_limit_reg;

    logic [CNT_W-1:0]   n_eff;
    logic [CNT_W-1:0]   m_eff;
    logic [CUR_W-1:0]   lim;
    logic [CUR_W:0]     cur_ext;
    logic [CUR_W:0]     lim_ext;
    logic [CUR_W:0]     sum_n;
    logic [CUR_W:0]     sum_m;
    logic [CUR_W:0]     sum_1;
    logic               over_n;
    logic               over_m;
    logic               over_1;
    logic               past_lim;
    logic               skip_n;
    logic               skip_m;
    logic [CNT_W-1:0]   part;
    logic               sgn;
    logic               rd_act;
    logic               signed_act;
    logic               wr_act;
    logic [WORD_AW-1:0] word;

    always_comb
    begin
        if (bit_count == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (bit_count > CNT_W'(MAX_FIELD_BITS))
        begin
            n_eff = CNT_W'(MAX_FIELD_BITS);
        end
        else
        begin
            n_eff = bit_count;
        end
    end

    assign m_eff    = n_eff - CNT_W'(1);
    assign lim      = (bit_limit_reg > LIMIT_CAP) ? LIMIT_CAP : bit_limit_reg;
    assign cur_ext  = {1'b0, cursor_reg};
    assign lim_ext  = {1'b0, lim};
    assign sum_n    = cur_ext + (CUR_W+1)'(n_eff);
    assign sum_m    = cur_ext + (CUR_W+1)'(m_eff);
    assign sum_1    = cur_ext + (CUR_W+1)'(1);
    assign over_n   = sum_n > lim_ext;
    assign over_m   = sum_m > lim_ext;
    assign over_1   = sum_1 > lim_ext;
    assign past_lim = cursor_reg > lim;
    assign skip_n   = (n_eff == CNT_W'(8)) && !past_lim && over_n;
    assign skip_m   = (m_eff == CNT_W'(8)) && !past_lim && over_m;

    always_comb
    begin
        cursor_next   = cursor_reg;
        overflow_next = overflow_reg;
        part          = '0;
        sgn           = 1'b0;
        rd_act        = 1'b0;
        signed_act    = 1'b0;
        wr_act        = 1'b0;
        case (action)
            ACT_WR_U:
            begin
                wr_act = 1'b1;
                if (over_n)
                begin
                    cursor_next   = lim;
                    overflow_next = 1'b1;
                end
                else
                begin
                    cursor_next = sum_n[CUR_W-1:0];
                    part        = n_eff;
                end
            end
            ACT_RD_U:
            begin
                rd_act = 1'b1;
                if (!skip_n)
                begin
                    if (over_n)
                    begin
                        cursor_next   = lim;
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        cursor_next = sum_n[CUR_W-1:0];
                        part        = n_eff;
                    end
                end
            end
            ACT_WR_S, ACT_RD_S:
            begin
                signed_act = 1'b1;
                rd_act     = (action == ACT_RD_S);
                wr_act     = (action == ACT_WR_S);
                if (rd_act && skip_m)
                begin
                    overflow_next = overflow_reg || over_1;
                    sgn           = !(overflow_reg || over_1);
                    cursor_next   = sgn ? sum_1[CUR_W-1:0] : cursor_reg;
                end
                else if (over_m)
                begin
                    cursor_next   = lim;
                    overflow_next = 1'b1;
                end
                else
                begin
                    part          = m_eff;
                    overflow_next = overflow_reg || over_n;
                    sgn           = !(overflow_reg || over_n);
                    cursor_next   = sgn ? sum_n[CUR_W-1:0] : sum_m[CUR_W-1:0];
                end
            end
            ACT_SEEK:
            begin
                cursor_next = position;
            end
            ACT_CLEAR:
            begin
                cursor_next   = '0;
                overflow_next = 1'b0;
            end
            default:
            begin
                cursor_next = cursor_reg;
            end
        endcase
    end

    assign word = cursor_reg[SH_W +: WORD_AW];

    always_comb
    begin
        op.is_read     = rd_act;
        op.is_signed   = signed_act;
        op.sgn_present = sgn;
        op.width       = part + CNT_W'(sgn);
        op.is_write    = wr_act && (op.width != '0);
        op.part        = part;
        op.ext         = m_eff;
        op.sh          = cursor_reg[SH_W-1:0];
        op.lo_odd      = word[0];
        op.odd_addr    = word[WORD_AW-1:1];
        op.even_addr   = word[WORD_AW-1:1] + BANK_AW'(word[0]);
        op.field       = (value & field_mask(part))
                       | (DATA_W'(sgn & value[DATA_W-1]) << part);
        op.ovf         = overflow_next;
        op.cursor      = cursor_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            overflow_reg  <= 1'b0;
            bit_limit_reg <= LIMIT_RESET;
        end
        else
        begin
            if (accept)
            begin
                cursor_reg   <= cursor_next;
                overflow_reg <= overflow_next;
            end
            if (bit_limit_we)
            begin
                bit_limit_reg <= bit_limit;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bfsb_align.sv =====
`default_nettype none

module bfsb_align import bfsb_pkg::*;
(
    input  bfsb_op_t                op,
    input  wire logic [DATA_W-1:0]  rd_even,
    input  wire logic [DATA_W-1:0]  rd_odd,
    output logic      [DATA_W-1:0]  read_value,
    output bfsb_wr_t                wr
);

    logic [DATA_W-1:0]   lo_word;
    logic [DATA_W-1:0]   hi_word;
    logic [2*DATA_W-1:0] pair;
    logic [2*DATA_W-1:0] shifted;
    logic [2*DATA_W-1:0] wmask;
    logic [2*DATA_W-1:0] wdata;
    logic [2*DATA_W-1:0] merged;
    logic [DATA_W-1:0]   part_val;
    logic                sign_bit;
    logic                lo_we;
    logic                hi_we;

    assign lo_word = op.lo_odd ? rd_odd : rd_even;
    assign hi_word = op.lo_odd ? rd_even : rd_odd;
    assign pair    = {hi_word, lo_word};
    assign shifted = pair >> op.sh;

    assign part_val = shifted[DATA_W-1:0] & field_mask(op.part);
    assign sign_bit = op.is_signed && op.sgn_present && shifted[op.part[SH_W-1:0]];

    always_comb
    begin
        if (!op.is_read)
        begin
            read_value = '0;
        end
        else if (sign_bit)
        begin
            read_value = part_val | ({DATA_W{1'b1}} << op.ext);
        end
        else
        begin
            read_value = part_val;
        end
    end

    assign wmask  = {{DATA_W{1'b0}}, field_mask(op.width)} << op.sh;
    assign wdata  = {{DATA_W{1'b0}}, op.field} << op.sh;
    assign merged = (pair & ~wmask) | (wdata & wmask);
    assign lo_we  = op.is_write && (|wmask[DATA_W-1:0]);
    assign hi_we  = op.is_write && (|wmask[2*DATA_W-1:DATA_W]);

    always_comb
    begin
        wr.even_addr = op.even_addr;
        wr.odd_addr  = op.odd_addr;
        if (op.lo_odd)
        begin
            wr.odd_we    = lo_we;
            wr.odd_data  = merged[DATA_W-1:0];
            wr.even_we   = hi_we;
            wr.even_data = merged[2*DATA_W-1:DATA_W];
        end
        else
        begin
            wr.even_we   = lo_we;
            wr.even_data = merged[DATA_W-1:0];
            wr.odd_we    = hi_we;
            wr.odd_data  = merged[2*DATA_W-1:DATA_W];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bit_field_stream_buffer.sv =====
`default_nettype none
// Channel    Handshake              Payload
// in         in_valid / in_stall    action, value, bit_count, position
// out        out_valid / out_stall  read_value, overflow, bit_position
// bit_limit  bit_limit_we           bit_limit
//
// One transaction per cycle while in_stall is low; a result passes the merge stage into the output register.
// Each transaction is a registered read of the even/odd word banks, then merge and write back.
// Reset (rst_n, async) clears cursor, overflow and valids; bit_limit returns to 16384.
// Memory contents are undefined until written; there is no clearing pass.
// in_stall rises only while the merge stage and the output register are both held by out_stall.

module bit_field_stream_buffer import bfsb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [ACT_W-1:0]  action,
    input  wire logic [DATA_W-1:0] value,
    input  wire logic [CNT_W-1:0]  bit_count,
    input  wire logic [CUR_W-1:0]  position,
    input  wire logic              bit_limit_we,
    input  wire logic [CUR_W-1:0]  bit_limit,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [DATA_W-1:0] read_value,
    output logic                   overflow,
    output logic      [CUR_W-1:0]  bit_position
);

    logic              accept;
    logic              s2_adv;
    logic              s2_valid_reg;
    logic              s2_valid_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    bfsb_op_t          op;
    bfsb_op_t          s2_op_reg;
    bfsb_wr_t          wr;
    logic [DATA_W-1:0] rd_even;
    logic [DATA_W-1:0] rd_odd;
    logic [DATA_W-1:0] s2_read_value;
    logic [DATA_W-1:0] read_value_reg;
    logic              overflow_reg;
    logic [CUR_W-1:0]  bit_position_reg;

    assign s2_adv   = s2_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s2_valid_reg && out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign s2_valid_next  = accept || (s2_valid_reg && !s2_adv);
    assign out_valid_next = s2_adv || (out_valid_reg && out_stall);

    bfsb_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .action       (action),
        .value        (value),
        .bit_count    (bit_count),
        .position     (position),
        .bit_limit_we (bit_limit_we),
        .bit_limit    (bit_limit),
        .op           (op)
    );

    bfsb_bank u_bank_even
    (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (op.even_addr),
        .wr_en   (wr.even_we && s2_adv),
        .wr_addr (wr.even_addr),
        .wr_data (wr.even_data),
        .rd_data (rd_even)
    );

    bfsb_bank u_bank_odd
    (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (op.odd_addr),
        .wr_en   (wr.odd_we && s2_adv),
        .wr_addr (wr.odd_addr),
        .wr_data (wr.odd_data),
        .rd_data (rd_odd)
    );

    bfsb_align u_align
    (
        .op         (s2_op_reg),
        .rd_even    (rd_even),
        .rd_odd     (rd_odd),
        .read_value (s2_read_value),
        .wr         (wr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_op_reg <= op;
        end
        if (s2_adv)
        begin
            read_value_reg   <= s2_read_value;
            overflow_reg     <= s2_op_reg.ovf;
            bit_position_reg <= s2_op_reg.cursor;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_value   = read_value_reg;
    assign overflow     = overflow_reg;
    assign bit_position = bit_position_reg;

endmodule

`default_nettype wire

// ===== rtl/bfsb_checker.sv =====
`default_nettype none
`include "bit_field_stream_buffer_macros.svh"

module bfsb_checker import bfsb_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_stall,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic [DATA_W-1:0] read_value,
    input wire logic              overflow,
    input wire logic [CUR_W-1:0]  bit_position
);

    logic                    in_take;
    logic                    out_free;
    logic                    out_held;
    logic [DATA_W+CUR_W:0]   result_bits;

    assign in_take     = in_valid && !in_stall;
    assign out_free    = !out_valid || !out_stall;
    assign out_held    = out_valid && out_stall;
    assign result_bits = {read_value, overflow, bit_position};

    // backpressure comes only from a held output
    `BFSB_ASSERT_IMP(a_stall_source, in_stall, out_held, "in_stall without held output")

    // an accepted transaction reaches the output once the output is free to take it
    `BFSB_ASSERT_NXT(a_latency, in_take ##1 out_free, out_valid, "result missing after acceptance")

    // no result without an earlier acceptance
    `BFSB_ASSERT_IMP(a_no_phantom, $rose(out_valid), $past(in_take, 2), "result without transaction")

    `BFSB_ASSERT_NXT(a_hold, out_held, out_valid && $stable(result_bits), "held result changed")

endmodule

bind bit_field_stream_buffer bfsb_checker u_bfsb_checker (.*);

`default_nettype wire

// ===== dv/tb_bit_field_stream_buffer.sv =====
`timescale 1ns / 100ps

module tb_bit_field_stream_buffer;
    import bfsb_pkg::*;

    localparam logic [ACT_W-1:0] ACT_SPARE = 3'd6;
    localparam int STREAM_BITS     = BUFFER_WORDS * MAX_FIELD_BITS;
    localparam int WATCHDOG_CYCLES = 3000;
    localparam int NUM_PHASES      = 9;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [DATA_W-1:0] value;
        logic [CNT_W-1:0]  bit_count;
        logic [CUR_W-1:0]  position;
    } field_op_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        logic              overflow;
        logic [CUR_W-1:0]  bit_position;
    } field_outcome_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [ACT_W-1:0]  action = '0;
    logic [DATA_W-1:0] value = '0;
    logic [CNT_W-1:0]  bit_count = '0;
    logic [CUR_W-1:0]  position = '0;
    logic              bit_limit_we = 1'b0;
    logic [CUR_W-1:0]  limit_wdata = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [DATA_W-1:0] read_value;
    logic              overflow;
    logic [CUR_W-1:0]  bit_position;

    // slot 0 plans the stimulus ahead of time, slot 1 tracks accepted transactions
    logic [DATA_W-1:0] word_store  [0:1][0:BUFFER_WORDS-1];
    bit                bit_written [0:1][0:STREAM_BITS-1];
    logic [CUR_W-1:0]  stream_pos  [0:1];
    logic              ovf_flag    [0:1];
    logic [CUR_W-1:0]  limit_reg   [0:1];
    bit                touched_unwritten;

    field_op_t      pending_field_ops [$];
    field_outcome_t predicted_outcomes [$];

    int planned = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;
    int send_gap = 0;
    int send_burst = 0;
    int recv_stall = 0;
    int recv_burst = 0;

    bit_field_stream_buffer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .value        (value),
        .bit_count    (bit_count),
        .position     (position),
        .bit_limit_we (bit_limit_we),
        .bit_limit    (limit_wdata),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_value   (read_value),
        .overflow     (overflow),
        .bit_position (bit_position)
    );

    always #6 clk = ~clk;

    function automatic int active_limit(int s);
        int lim;
        lim = int'(limit_reg[s]);
        return (lim > STREAM_BITS) ? STREAM_BITS : lim;
    endfunction

    function automatic void put_bits(int s, int pos, int n, logic [DATA_W-1:0] v);
        int b;
        for (int i = 0; i < n; i++)
        begin
            b = pos + i;
            word_store[s][(b / DATA_W) % BUFFER_WORDS][b % DATA_W] = v[i];
            bit_written[s][b % STREAM_BITS] = 1'b1;
        end
    endfunction

    function automatic logic [DATA_W-1:0] get_bits(int s, int pos, int n);
        logic [DATA_W-1:0] v;
        int                b;
        v = '0;
        for (int i = 0; i < n; i++)
        begin
            b = pos + i;
            v[i] = word_store[s][(b / DATA_W) % BUFFER_WORDS][b % DATA_W];
            if (!bit_written[s][b % STREAM_BITS])
                touched_unwritten = 1'b1;
        end
        return v;
    endfunction

    function automatic void put_field(int s, logic [DATA_W-1:0] v, int n);
        int lim;
        int c;
        lim = active_limit(s);
        c = int'(stream_pos[s]);
        if (c + n > lim)
        begin
            ovf_flag[s] = 1'b1;
            stream_pos[s] = CUR_W'(lim);
        end
        else
        begin
            put_bits(s, c, n, v);
            stream_pos[s] = CUR_W'(c + n);
        end
    endfunction

    function automatic logic [DATA_W-1:0] take_field(int s, int n);
        int lim;
        int c;
        logic [DATA_W-1:0] v;
        lim = active_limit(s);
        c = int'(stream_pos[s]);
        if (n == 8 && c <= lim && lim - c < 8)
            return '0;
        if (c + n > lim)
        begin
            ovf_flag[s] = 1'b1;
            stream_pos[s] = CUR_W'(lim);
            return '0;
        end
        v = get_bits(s, c, n);
        stream_pos[s] = CUR_W'(c + n);
        return v;
    endfunction

    function automatic logic sign_refused(int s);
        if (int'(stream_pos[s]) + 1 > active_limit(s))
            ovf_flag[s] = 1'b1;
        return ovf_flag[s];
    endfunction

    function automatic void put_sign(int s, logic b);
        if (!sign_refused(s))
        begin
            put_bits(s, int'(stream_pos[s]), 1, DATA_W'(b));
            stream_pos[s] = stream_pos[s] + 1'b1;
        end
    endfunction

    function automatic logic take_sign(int s);
        logic [DATA_W-1:0] b;
        if (sign_refused(s))
            return 1'b0;
        b = get_bits(s, int'(stream_pos[s]), 1);
        stream_pos[s] = stream_pos[s] + 1'b1;
        return b[0];
    endfunction

    function automatic field_outcome_t apply_field_op(int s, field_op_t op);
        field_outcome_t r;
        int             n;
        logic [DATA_W-1:0] res;
        if (op.bit_count == '0)
            n = 1;
        else if (int'(op.bit_count) > MAX_FIELD_BITS)
            n = MAX_FIELD_BITS;
        else
            n = int'(op.bit_count);
        res = '0;
        case (op.action)
            ACT_WR_U:
                put_field(s, op.value, n);
            ACT_WR_S:
            begin
                put_field(s, op.value, n - 1);
                put_sign(s, op.value[DATA_W-1]);
            end
            ACT_RD_U:
                res = take_field(s, n);
            ACT_RD_S:
            begin
                res = take_field(s, n - 1);
                if (take_sign(s))
                    res = res - (DATA_W'(1) << (n - 1));
            end
            ACT_SEEK:
                stream_pos[s] = op.position;
            ACT_CLEAR:
            begin
                stream_pos[s] = '0;
                ovf_flag[s] = 1'b0;
            end
            default:
                ;
        endcase
        r.read_value = res;
        r.overflow = ovf_flag[s];
        r.bit_position = stream_pos[s];
        return r;
    endfunction

    function automatic field_op_t make_op(logic [ACT_W-1:0] act, logic [DATA_W-1:0] val,
                                          logic [CNT_W-1:0] cnt, logic [CUR_W-1:0] pos);
        field_op_t op;
        op.action = act;
        op.value = val;
        op.bit_count = cnt;
        op.position = pos;
        return op;
    endfunction

    // queue an op, turning a read of never-written bits into an unsigned write at the same place
    task automatic plan_op(field_op_t op);
        field_op_t      o;
        field_outcome_t unused;
        logic [CUR_W-1:0] saved_pos;
        logic           saved_ovf;
        o = op;
        saved_pos = stream_pos[0];
        saved_ovf = ovf_flag[0];
        touched_unwritten = 1'b0;
        unused = apply_field_op(0, o);
        if (touched_unwritten)
        begin
            stream_pos[0] = saved_pos;
            ovf_flag[0] = saved_ovf;
            o.action = ACT_WR_U;
            unused = apply_field_op(0, o);
        end
        pending_field_ops.push_back(o);
        planned++;
    endtask

    task automatic plan_directed();
        plan_op(make_op(ACT_WR_U, 32'hFFFF_FFFF, 6'd32, '0));
        plan_op(make_op(ACT_WR_U, 32'hFFFF_FFFE, 6'd1, '0));
        plan_op(make_op(ACT_WR_S, 32'h8000_0000, 6'd32, '0));
        plan_op(make_op(ACT_WR_S, 32'hFFFF_FFFF, 6'd1, '0));
        plan_op(make_op(ACT_WR_U, 32'h1234_5678, 6'd63, '0));
        plan_op(make_op(ACT_WR_S, 32'hFFFF_FF80, 6'd9, '0));
        plan_op(make_op(ACT_WR_U, 32'h0000_00A5, 6'd8, '0));
        plan_op(make_op(ACT_SEEK, 32'h0, 6'd0, '0));
        plan_op(make_op(ACT_RD_U, 32'h0, 6'd32, '0));
        plan_op(make_op(ACT_RD_U, 32'h0, 6'd1, '0));
        plan_op(make_op(ACT_RD_S, 32'h0, 6'd32, '0));
        plan_op(make_op(ACT_RD_S, 32'h0, 6'd1, '0));
        plan_op(make_op(ACT_RD_U, 32'h0, 6'd63, '0));
        plan_op(make_op(ACT_RD_S, 32'h0, 6'd9, '0));
        plan_op(make_op(ACT_RD_U, 32'h0, 6'd8, '0));
        plan_op(make_op(ACT_SPARE, 32'hFFFF_FFFF, 6'd63, '1));
        plan_op(make_op(ACT_SEEK, 32'h0, 6'd0, CUR_W'(16380)));
        plan_op(make_op(ACT_WR_U, 32'h0000_000F, 6'd4, '0));
        plan_op(make_op(ACT_SEEK, 32'h0, 6'd0, CUR_W'(16380)));
        plan_op(make_op(ACT_RD_U, 32'h0, 6'd8, '0));
        plan_op(make_op(ACT_RD_S, 32'h0, 6'd9, '0));
        plan_op(make_op(ACT_WR_U, 32'h0000_00FF, 6'd8, '0));
        plan_op(make_op(ACT_SEEK, 32'h0, 6'd0, CUR_W'(200)));
        plan_op(make_op(ACT_WR_S, 32'h8000_0005, 6'd4, '0));
        plan_op(make_op(ACT_CLEAR, 32'h0, 6'd0, '0));
    endtask

    // write a run of fields, return to its start and read it back
    task automatic plan_sequence();
        int               count;
        int               start;
        int               alim;
        logic [CNT_W-1:0] widths [12];
        logic             signs [12];
        alim = active_limit(0);
        count = $urandom_range(1, 12);
        case ($urandom_range(0, 2))
            0: start = 0;
            1: start = $urandom_range(0, alim);
            default: start = alim - $urandom_range(0, (alim < 48) ? alim : 48);
        endcase
        if (start == 0 && $urandom_range(0, 1) == 1)
            plan_op(make_op(ACT_CLEAR, $urandom, CNT_W'($urandom), CUR_W'($urandom)));
        else
            plan_op(make_op(ACT_SEEK, $urandom, CNT_W'($urandom), CUR_W'(start)));
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                widths[i] = CNT_W'($urandom_range(0, 63));
            else
                widths[i] = CNT_W'($urandom_range(1, 32));
            signs[i] = 1'($urandom_range(0, 1));
            plan_op(make_op(signs[i] ? ACT_WR_S : ACT_WR_U, $urandom, widths[i],
                            CUR_W'($urandom)));
        end
        plan_op(make_op(ACT_SEEK, $urandom, CNT_W'($urandom), CUR_W'(start)));
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                signs[i] = !signs[i];
            plan_op(make_op(signs[i] ? ACT_RD_S : ACT_RD_U, $urandom, widths[i],
                            CUR_W'($urandom)));
        end
    endtask

    task automatic plan_noise();
        int alim;
        int pos;
        alim = active_limit(0);
        repeat ($urandom_range(1, 4))
        begin
            if ($urandom_range(0, 1) == 1)
                pos = $urandom_range(0, alim);
            else
                pos = $urandom_range(0, 32767);
            plan_op(make_op(ACT_W'($urandom_range(0, 7)), $urandom,
                            CNT_W'($urandom_range(0, 63)), CUR_W'(pos)));
        end
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (pending_field_ops.size() != 0 || in_valid || predicted_outcomes.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_bit_limit(logic [CUR_W-1:0] v);
        @(posedge clk);
        bit_limit_we <= 1'b1;
        limit_wdata <= v;
        @(posedge clk);
        bit_limit_we <= 1'b0;
        limit_reg[0] = v;
        limit_reg[1] = v;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action <= '0;
            value <= '0;
            bit_count <= '0;
            position <= '0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predicted_outcomes.push_back(
                    apply_field_op(1, make_op(action, value, bit_count, position)));
            // hold the current transaction while stalled
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_field_ops.size() != 0)
                begin
                    {action, value, bit_count, position} <= pending_field_ops.pop_front();
                    in_valid <= 1'b1;
                    if (send_burst > 0)
                    begin
                        send_burst--;
                        send_gap = 0;
                    end
                    else if ($urandom_range(0, 15) == 0)
                    begin
                        send_burst = $urandom_range(10, 40);
                        send_gap = 0;
                    end
                    else
                        send_gap = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(0, 11);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        field_outcome_t exp_out;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (predicted_outcomes.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h %b %h",
                             $time, read_value, overflow, bit_position);
                    mismatch_count++;
                end
                else
                begin
                    exp_out = predicted_outcomes.pop_front();
                    if (read_value !== exp_out.read_value)
                    begin
                        $display("%0t: read_value expected %h actual %h",
                                 $time, exp_out.read_value, read_value);
                        mismatch_count++;
                    end
                    if (overflow !== exp_out.overflow)
                    begin
                        $display("%0t: overflow expected %b actual %b",
                                 $time, exp_out.overflow, overflow);
                        mismatch_count++;
                    end
                    if (bit_position !== exp_out.bit_position)
                    begin
                        $display("%0t: bit_position expected %0d actual %0d",
                                 $time, exp_out.bit_position, bit_position);
                        mismatch_count++;
                    end
                end
                if (recv_burst > 0)
                begin
                    recv_burst--;
                    recv_stall = 0;
                end
                else if ($urandom_range(0, 15) == 0)
                begin
                    recv_burst = $urandom_range(10, 40);
                    recv_stall = 0;
                end
                else
                    recv_stall = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(0, 11);
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("[bit_field_stream_buffer] ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int phase_limit [NUM_PHASES];
        int target;
        phase_limit = '{16384, 0, 1, 8, 40, 0, 32767, 16383, 16385};
        phase_limit[5] = $urandom_range(200, 3000);
        for (int s = 0; s < 2; s++)
        begin
            stream_pos[s] = '0;
            ovf_flag[s] = 1'b0;
            limit_reg[s] = LIMIT_RESET;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            set_bit_limit(CUR_W'(phase_limit[ph]));
            if (ph == 0)
                plan_directed();
            target = planned + ((ph == 0) ? 50 : 64);
            while (planned < target)
            begin
                if ($urandom_range(0, 3) != 0)
                    plan_sequence();
                else
                    plan_noise();
            end
            drain();
        end
        if (mismatch_count == 0)
            $display("[bit_field_stream_buffer] OK");
        else
            $display("[bit_field_stream_buffer] ERROR");
        $finish;
    end

endmodule
